// ===== rtl/core/bks_pkg.sv =====
package bks_pkg;

    // Command codes carried on the request tuser
    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_SKIP    = 2'd2;
    localparam logic [1:0] CMD_SYNC    = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_INACTIVE = 2'd2;

    // Key phase encoding
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_BUSY  = 2'd1;
    localparam logic [1:0] PH_RESET = 2'd2;

    // Widths of the stream fields
    localparam int KEY_W = 5;

    // One result, new_key in the lowest bits
    typedef struct packed {
        logic [1:0]       status;
        logic             wait_res;
        logic [KEY_W-1:0] new_key;
    } result_t;

endpackage

// ===== rtl/core/bks_ram.sv =====
module bks_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with registered output
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/barrier_key_synchronizer.sv =====
// Barrier among up to NUM_KEYS participant keys. A request carries a command
// (allocate, release, skip, sync) and a key handle; each request yields one
// result with the allocated handle, the sync answer (1 keep waiting, 0 go)
// and a status. Requests are taken one at a time; allocate checks one key
// per cycle, lowest first. A sync uses the single read port of the
// count/phase memory, which is swept once to look for keys still at count
// zero and, when none remain, once more to decrement every active key.
// A finished result waits in the output register while the next request
// is accepted.
module barrier_key_synchronizer #(
    parameter int NUM_KEYS   = 32,
    parameter int COUNT_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // key[4:0], zero pad
    input  logic [1:0] s_tuser,   // cmd[1:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // new_key[4:0], wait_res[5], status[7:6]
);

    localparam int IDX_W = $clog2(NUM_KEYS);
    localparam int CW    = $clog2(NUM_KEYS + 1);
    localparam int KW    = (IDX_W > bks_pkg::KEY_W) ? IDX_W : bks_pkg::KEY_W;
    localparam int EW    = COUNT_BITS + 2;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALLOC = 3'd1;
    localparam logic [2:0] S_KEY   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_ADV   = 3'd4;
    localparam logic [2:0] S_PUSH  = 3'd5;

    localparam logic [CW-1:0] NUM_C = CW'(NUM_KEYS);

    logic [2:0]            state_reg, state_next;
    logic [NUM_KEYS-1:0]   active_reg, active_next;
    logic [CW-1:0]         scan_reg, scan_next;
    logic                  pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]      pipe_idx_reg, pipe_idx_next;
    logic                  pend_reg, pend_next;
    logic                  out_vld_reg, out_vld_next;
    logic [1:0]            cmd_reg, cmd_next;
    logic [IDX_W-1:0]      key_reg, key_next;
    logic [1:0]            phk_reg, phk_next;
    bks_pkg::result_t      res_reg, res_next;
    bks_pkg::result_t      out_reg, out_next;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [EW-1:0]         wr_data;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [EW-1:0]         rd_data;

    logic [KW-1:0]         key_wide;
    logic                  key_ok;
    logic [IDX_W-1:0]      key_idx;
    logic [COUNT_BITS-1:0] ent_count;
    logic [1:0]            ent_phase;
    logic                  issue;
    logic [KW-1:0]         scan_wide;

    // Per-key count and phase, packed as {count, phase}
    bks_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_KEYS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Decode the request handle
    assign key_wide  = KW'(s_tdata[bks_pkg::KEY_W-1:0]);
    assign key_ok    = ({1'b0, key_wide} < (KW + 1)'(NUM_KEYS));
    assign key_idx   = key_wide[IDX_W-1:0];
    assign ent_count = rd_data[EW-1:2];
    assign ent_phase = rd_data[1:0];
    assign issue     = (scan_reg < NUM_C);
    assign scan_wide = KW'(scan_reg[IDX_W-1:0]);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    // Sequence one request
    always_comb
    begin
        state_next    = state_reg;
        active_next   = active_reg;
        scan_next     = scan_reg;
        pipe_vld_next = 1'b0;
        pipe_idx_next = pipe_idx_reg;
        pend_next     = pend_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        phk_next      = phk_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        out_vld_next  = out_vld_reg;
        wr_en         = 1'b0;
        wr_addr       = key_reg;
        wr_data       = {ent_count, ent_phase};
        rd_en         = 1'b0;
        rd_addr       = key_reg;

        // Drain the output register
        if (out_vld_reg && m_tready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next = s_tuser;
                    key_next = key_idx;
                    res_next = '0;
                    if (s_tuser == bks_pkg::CMD_ALLOC)
                    begin
                        scan_next  = '0;
                        state_next = S_ALLOC;
                    end
                    else if (!key_ok || !active_reg[key_idx])
                    begin
                        res_next.status = bks_pkg::ST_INACTIVE;
                        state_next      = S_PUSH;
                    end
                    else if (s_tuser == bks_pkg::CMD_RELEASE)
                    begin
                        active_next[key_idx] = 1'b0;
                        state_next           = S_PUSH;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = key_idx;
                        state_next = S_KEY;
                    end
                end
            end

            S_ALLOC:
            begin
                // Check one key per cycle, lowest first
                if (!issue)
                begin
                    res_next.status = bks_pkg::ST_FULL;
                    state_next      = S_PUSH;
                end
                else if (!active_reg[scan_reg[IDX_W-1:0]])
                begin
                    active_next[scan_reg[IDX_W-1:0]] = 1'b1;
                    wr_en            = 1'b1;
                    wr_addr          = scan_reg[IDX_W-1:0];
                    wr_data          = {{COUNT_BITS{1'b0}}, bks_pkg::PH_IDLE};
                    res_next.new_key = scan_wide[bks_pkg::KEY_W-1:0];
                    state_next       = S_PUSH;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_KEY:
            begin
                wr_en = 1'b1;
                if (cmd_reg == bks_pkg::CMD_SKIP)
                begin
                    // Raise the count, saturating, and go idle
                    if (ent_count != {COUNT_BITS{1'b1}})
                    begin
                        wr_data = {ent_count + 1'b1, bks_pkg::PH_IDLE};
                    end
                    else
                    begin
                        wr_data = {ent_count, bks_pkg::PH_IDLE};
                    end
                    state_next = S_PUSH;
                end
                else if (ent_phase == bks_pkg::PH_RESET)
                begin
                    wr_data    = {ent_count, bks_pkg::PH_IDLE};
                    state_next = S_PUSH;
                end
                else
                begin
                    // Mark arrival, then look for keys still pending
                    if (ent_count == '0)
                    begin
                        wr_data  = {COUNT_BITS'(1), bks_pkg::PH_BUSY};
                        phk_next = bks_pkg::PH_BUSY;
                    end
                    else
                    begin
                        phk_next = ent_phase;
                    end
                    scan_next  = '0;
                    pend_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (issue)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = scan_reg[IDX_W-1:0];
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + 1'b1;
                end
                if (pipe_vld_reg && active_reg[pipe_idx_reg] && ent_count == '0)
                begin
                    pend_next = 1'b1;
                end
                if (!issue && !pipe_vld_reg)
                begin
                    if (pend_reg)
                    begin
                        res_next.wait_res = (phk_reg != bks_pkg::PH_IDLE);
                        state_next        = S_PUSH;
                    end
                    else
                    begin
                        scan_next  = '0;
                        state_next = S_ADV;
                    end
                end
            end

            S_ADV:
            begin
                // Decrement every active key and enter reset phase
                if (issue)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = scan_reg[IDX_W-1:0];
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + 1'b1;
                end
                if (pipe_vld_reg && active_reg[pipe_idx_reg])
                begin
                    wr_en   = 1'b1;
                    wr_addr = pipe_idx_reg;
                    if (ent_count != '0)
                    begin
                        wr_data = {ent_count - 1'b1, bks_pkg::PH_RESET};
                    end
                    else
                    begin
                        wr_data = {ent_count, bks_pkg::PH_RESET};
                    end
                end
                if (!issue && !pipe_vld_reg)
                begin
                    res_next.wait_res = 1'b1;
                    state_next        = S_PUSH;
                end
            end

            S_PUSH:
            begin
                // Hand the result over once the output slot is free
                if (!out_vld_reg || m_tready)
                begin
                    out_next     = res_reg;
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            active_reg   <= '0;
            pipe_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            pipe_vld_reg <= pipe_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        pipe_idx_reg <= pipe_idx_next;
        pend_reg     <= pend_next;
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        phk_reg      <= phk_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

endmodule

// ===== tb/testbench.sv =====
module testbench;

    import bks_pkg::*;

    localparam int NUM_KEYS    = 32;
    localparam int COUNT_BITS  = 8;
    localparam int TOTAL_ITEMS = 1850;
    localparam int QUIET_TAIL  = 200;
    localparam int DRAIN_WAIT  = 2 * NUM_KEYS + 16;
    localparam int CYCLE_LIMIT = 1000000;

    // Predicts the answer to every request and keeps the answers still owed
    class barrier_tracker;
        bit                  active [NUM_KEYS];
        logic [COUNT_BITS-1:0] count [NUM_KEYS];
        logic [1:0]          phase  [NUM_KEYS];
        result_t             expected_answers [$];
        int errors;
        int n_advance;
        int n_go;
        int n_full;
        int n_inactive;

        function new();
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                active[i] = 1'b0;
                count[i]  = '0;
                phase[i]  = PH_IDLE;
            end
        endfunction

        function int active_count();
            int n;
            n = 0;
            for (int i = 0; i < NUM_KEYS; i++)
                n += active[i];
            return n;
        endfunction

        // Return a random allocated key, or -1 when the pool is empty
        function int pick_active();
            int held [$];
            for (int i = 0; i < NUM_KEYS; i++)
                if (active[i])
                    held.push_back(i);
            if (held.size() == 0)
                return -1;
            return held[$urandom_range(0, held.size() - 1)];
        endfunction

        // Apply one accepted request and queue the answer it must produce
        function void note_request(logic [1:0] cmd, logic [KEY_W-1:0] key);
            result_t ans;
            bit      found;
            bit      arrived_all;
            ans = '0;
            if (cmd == CMD_ALLOC)
            begin
                found = 1'b0;
                for (int i = 0; i < NUM_KEYS && !found; i++)
                begin
                    if (!active[i])
                    begin
                        active[i]   = 1'b1;
                        count[i]    = '0;
                        phase[i]    = PH_IDLE;
                        ans.new_key = KEY_W'(i);
                        found       = 1'b1;
                    end
                end
                if (!found)
                begin
                    ans.status = ST_FULL;
                    n_full++;
                end
            end
            else if (int'(key) >= NUM_KEYS || !active[key])
            begin
                ans.status = ST_INACTIVE;
                n_inactive++;
            end
            else if (cmd == CMD_RELEASE)
            begin
                active[key] = 1'b0;
                count[key]  = '0;
                phase[key]  = PH_IDLE;
            end
            else if (cmd == CMD_SKIP)
            begin
                if (count[key] != '1)
                    count[key]++;
                phase[key] = PH_IDLE;
            end
            else
            begin
                if (phase[key] == PH_RESET)
                    phase[key] = PH_IDLE;
                else
                begin
                    // Mark arrival, then open the barrier once no key is left at zero
                    if (count[key] == '0)
                    begin
                        count[key] = COUNT_BITS'(1);
                        phase[key] = PH_BUSY;
                    end
                    arrived_all = 1'b1;
                    for (int i = 0; i < NUM_KEYS; i++)
                        if (active[i] && count[i] == '0)
                            arrived_all = 1'b0;
                    if (arrived_all)
                    begin
                        n_advance++;
                        for (int i = 0; i < NUM_KEYS; i++)
                        begin
                            if (active[i])
                            begin
                                if (count[i] != '0)
                                    count[i]--;
                                phase[i] = PH_RESET;
                            end
                        end
                    end
                    ans.wait_res = (phase[key] != PH_IDLE);
                end
                if (!ans.wait_res)
                    n_go++;
            end
            expected_answers.push_back(ans);
        endfunction

        // Compare one delivered answer with the oldest one owed
        function void check_answer(logic [7:0] data);
            result_t got;
            result_t want;
            got = result_t'(data);
            if (expected_answers.size() == 0)
            begin
                errors++;
                $display("%0t: answer %h arrived with no request outstanding", $time, data);
                return;
            end
            want = expected_answers.pop_front();
            if (got.new_key !== want.new_key)
            begin
                errors++;
                $display("%0t: new_key expected %0d got %0d", $time, want.new_key, got.new_key);
            end
            if (got.wait_res !== want.wait_res)
            begin
                errors++;
                $display("%0t: wait_res expected %0d got %0d", $time, want.wait_res,
                         got.wait_res);
            end
            if (got.status !== want.status)
            begin
                errors++;
                $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [1:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;

    barrier_tracker tracker;
    int  n_sent;
    int  cycle_count;
    int  sink_hold;
    bit  src_idle_en;
    bit  sink_idle_en;

    barrier_key_synchronizer #(
        .NUM_KEYS   (NUM_KEYS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Stall the answer side in bursts of random length
    always @(posedge clk)
    begin
        if (sink_hold != 0)
            sink_hold <= sink_hold - 1;
        else if (sink_idle_en && $urandom_range(0, 7) == 0)
        begin
            m_tready  <= 1'b0;
            sink_hold <= $urandom_range(0, 9);
        end
        else
            m_tready <= 1'b1;
    end

    // Check every accepted answer
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_answer(m_tdata);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offer one request and hold it until accepted; call right after a rising edge
    task automatic send_request(input logic [1:0] cmd, input logic [KEY_W-1:0] key);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_request(cmd, key);
        n_sent++;
        if (src_idle_en && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // Hold off new requests until every owed answer has arrived
    task automatic drain_answers();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.expected_answers.size() != 0)
            @(posedge clk);
    endtask

    // One request from a mix of noise and well-formed traffic on held keys
    task automatic random_request(input int target);
        int r;
        int n;
        int k;
        r = $urandom_range(0, 99);
        n = tracker.active_count();
        k = tracker.pick_active();
        if (r < 12)
            send_request(2'($urandom_range(0, 3)), KEY_W'($urandom_range(0, 31)));
        else if (n == 0 || (n < target && r < 40))
            send_request(CMD_ALLOC, KEY_W'($urandom_range(0, 31)));
        else if (r < 72 || (r >= 86 && n <= 1))
            send_request(CMD_SYNC, KEY_W'(k));
        else if (r < 86)
            send_request(CMD_SKIP, KEY_W'(k));
        else
            send_request(CMD_RELEASE, KEY_W'(k));
    endtask

    // Fill the pool past full, run traffic on it, then release most keys
    task automatic fill_pool();
        while (tracker.active_count() < NUM_KEYS)
            send_request(CMD_ALLOC, KEY_W'($urandom_range(0, 31)));
        repeat (2) send_request(CMD_ALLOC, KEY_W'($urandom_range(0, 31)));
        repeat (20) random_request(NUM_KEYS);
        while (tracker.active_count() > 3)
        begin
            if ($urandom_range(0, 4) == 0)
                send_request(CMD_SYNC, KEY_W'(tracker.pick_active()));
            else
                send_request(CMD_RELEASE, KEY_W'(tracker.pick_active()));
        end
    endtask

    initial
    begin
        int target;
        int k;
        bit quiet;
        tracker      = new();
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_ALLOC;
        m_tready     = 1'b0;
        sink_hold    = 0;
        cycle_count  = 0;
        n_sent       = 0;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: inactive keys, allocation order, barrier open and go answer
        send_request(CMD_SYNC,    5'd0);
        send_request(CMD_RELEASE, 5'd31);
        send_request(CMD_SKIP,    5'd17);
        send_request(CMD_ALLOC,   5'd31);
        send_request(CMD_ALLOC,   5'd0);
        send_request(CMD_SYNC,    5'd0);
        send_request(CMD_SYNC,    5'd0);
        send_request(CMD_SYNC,    5'd1);
        send_request(CMD_SYNC,    5'd0);
        send_request(CMD_SKIP,    5'd1);
        send_request(CMD_SYNC,    5'd1);
        send_request(CMD_RELEASE, 5'd0);
        send_request(CMD_SYNC,    5'd0);
        send_request(CMD_ALLOC,   5'd21);
        send_request(CMD_SYNC,    5'd31);
        send_request(CMD_SKIP,    5'd0);
        send_request(CMD_SYNC,    5'd0);
        send_request(CMD_SYNC,    5'd1);
        send_request(CMD_RELEASE, 5'd1);
        send_request(CMD_RELEASE, 5'd0);

        // Drive one key's count into saturation, then sync it down
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        send_request(CMD_ALLOC, 5'd10);
        send_request(CMD_ALLOC, 5'd5);
        k = tracker.pick_active();
        repeat (258) send_request(CMD_SKIP, KEY_W'(k));
        repeat (12) send_request(CMD_SYNC, KEY_W'(tracker.pick_active()));
        drain_answers();

        // Random phases with varying pool sizes and idling
        while (n_sent < TOTAL_ITEMS)
        begin
            quiet        = (n_sent > TOTAL_ITEMS - QUIET_TAIL);
            src_idle_en  = !quiet && $urandom_range(0, 3) != 0;
            sink_idle_en = !quiet && $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 9) == 0)
                fill_pool();
            else
            begin
                target = ($urandom_range(0, 9) < 8) ? $urandom_range(2, 5)
                                                    : $urandom_range(6, NUM_KEYS);
                repeat ($urandom_range(30, 80)) random_request(target);
            end
            if ($urandom_range(0, 3) == 0)
                drain_answers();
        end

        // Wait out the tail and any late extra answers
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        drain_answers();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("ran %0d requests: %0d barrier openings, %0d go answers", n_sent,
                 tracker.n_advance, tracker.n_go);
        $display("rejections seen: %0d on a full pool, %0d on inactive keys",
                 tracker.n_full, tracker.n_inactive);
        if (tracker.errors == 0 && tracker.expected_answers.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/bks_pkg.sv
rtl/core/bks_ram.sv
rtl/core/barrier_key_synchronizer.sv
tb/testbench.sv
